### src/rid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the record id demultiplexer.
// No dependencies; every file but the two channel interfaces imports this package.
package rid_pkg;

	// Item operation codes
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_BYTE = 2'd1,
		OP_END  = 2'd2
	} op_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_END   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// Stream parser phase
	typedef enum logic [1:0] {
		PH_ID   = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2,
		PH_DROP = 2'd3
	} phase_t;

	// Controller states
	typedef enum logic {
		ST_IDLE    = 1'b0,
		ST_RESOLVE = 1'b1
	} ctrl_state_t;

	localparam logic [3:0] ID_BYTES_MAX   = 4'd8;
	localparam logic [3:0] ID_BYTES_RESET = 4'd1;
	localparam logic [3:0] LEN_PREFIX_LAST = 4'd3;

	// Input word payload
	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  entry_index;
		logic        entry_valid;
		logic [63:0] entry_key;
		logic [31:0] entry_length;
		logic [7:0]  data_byte;
	} item_t;

	// Result word payload
	typedef struct packed {
		kind_t       kind;
		logic [63:0] record_key;
		logic [7:0]  record_byte;
		logic        record_first;
		logic        record_last;
		logic [31:0] leftover_count;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic exec;     // handle the accepted word directly, with no table lookup
		logic capture;  // accepted byte needs a table lookup: register compares
		logic resolve;  // finish the lookup and emit
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic lookup_needed;
		logic out_free;
	} status_t;

endpackage

### src/rid_item_if.sv
`timescale 1ns / 1ps
// Input channel: valid/ready handshake with load, byte and end-of-block words.
// No dependencies.
interface rid_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [3:0]  entry_index;
	logic        entry_valid;
	logic [63:0] entry_key;
	logic [31:0] entry_length;
	logic [7:0]  data_byte;

	modport source (
		output valid, op, entry_index, entry_valid, entry_key, entry_length, data_byte,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, entry_valid, entry_key, entry_length, data_byte,
		output ready
	);
endinterface

### src/rid_result_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying tagged record bytes and status.
// No dependencies.
interface rid_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [63:0] record_key;
	logic [7:0]  record_byte;
	logic        record_first;
	logic        record_last;
	logic [31:0] leftover_count;

	modport source (
		output valid, kind, record_key, record_byte, record_first, record_last,
			leftover_count,
		input  ready
	);
	modport sink (
		input  valid, kind, record_key, record_byte, record_first, record_last,
			leftover_count,
		output ready
	);
endinterface

### src/rid_ctrl.sv
`timescale 1ns / 1ps
// Controller FSM: accepts input words and sequences the table lookup.
// Depends on rid_pkg.
module rid_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  rid_pkg::status_t status,
	output rid_pkg::cmd_t    cmd
);
	import rid_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        fire;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		fire       = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				item_ready = status.out_free;
				fire       = item_valid && status.out_free;
				if (fire) begin
					if (status.lookup_needed) begin
						cmd.capture = 1'b1;
						state_d     = ST_RESOLVE;
					end else begin
						cmd.exec = 1'b1;
					end
				end
			end
			ST_RESOLVE: begin
				// hold until the result register can take the word
				if (status.out_free) begin
					cmd.resolve = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### src/rid_datapath.sv
`timescale 1ns / 1ps
// Datapath: id table, stream parser registers, lookup compare and result register.
// Depends on rid_pkg; driven by rid_ctrl commands.
module rid_datapath #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             id_bytes_we,
	input  logic [3:0]       id_bytes_wdata,
	input  rid_pkg::item_t   item_word,
	input  rid_pkg::cmd_t    cmd,
	output rid_pkg::status_t status,
	output logic             res_valid,
	input  logic             res_ready,
	output rid_pkg::result_t res_word
);
	import rid_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// Table storage
	logic [TABLE_ENTRIES-1:0] slot_in_use_q;
	logic [63:0]              slot_key_q [TABLE_ENTRIES];
	logic [31:0]              slot_len_q [TABLE_ENTRIES];

	// Parser state
	logic [3:0]  id_bytes_q;
	phase_t      phase_q, phase_d;
	logic [63:0] key_q, key_d;
	logic [3:0]  pcnt_q, pcnt_d;
	logic [31:0] remain_q, remain_d;
	logic [31:0] since_q, since_d;

	// Lookup stage
	logic [TABLE_ENTRIES-1:0] match_s1;
	logic [7:0]               byte_s1;

	// Result register
	logic    res_valid_q;
	result_t res_q, res_d;
	logic    emit;

	logic [3:0]       nid;
	logic             load_we;
	logic [31:0]      since_inc;
	logic [31:0]      len_word;
	logic [IDX_W-1:0] hit_idx;
	logic             hit;
	logic [31:0]      hit_len;
	logic [7:0]       b;

	assign nid       = (id_bytes_q > ID_BYTES_MAX) ? ID_BYTES_MAX : id_bytes_q;
	assign since_inc = (since_q == '1) ? since_q : since_q + 32'd1;
	assign b         = item_word.data_byte;

	assign status.lookup_needed = (op_t'(item_word.op) == OP_BYTE) && (phase_q == PH_ID)
		&& (pcnt_q >= nid);
	assign status.out_free = !res_valid_q || res_ready;

	// Lowest matching slot wins
	always_comb begin
		hit_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (match_s1[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end
	assign hit     = |match_s1;
	assign hit_len = slot_len_q[hit_idx];

	// Next parser state and result word
	always_comb begin
		phase_d  = phase_q;
		key_d    = key_q;
		pcnt_d   = pcnt_q;
		remain_d = remain_q;
		since_d  = since_q;
		load_we  = 1'b0;
		emit     = 1'b0;
		len_word = remain_q;
		res_d.kind           = KIND_BYTE;
		res_d.record_key     = key_q;
		res_d.record_byte    = b;
		res_d.record_first   = 1'b0;
		res_d.record_last    = 1'b0;
		res_d.leftover_count = '0;

		if (cmd.exec) begin
			case (op_t'(item_word.op))
				OP_LOAD: begin
					load_we = 32'(item_word.entry_index) < TABLE_ENTRIES;
				end
				OP_BYTE: begin
					if (phase_q != PH_DROP) begin
						since_d = since_inc;
						emit    = 1'b1;
						case (phase_q)
							PH_ID: begin
								// collect one id byte, least significant first
								emit   = 1'b0;
								key_d  = key_q | (64'(b) << {pcnt_q[2:0], 3'b000});
								pcnt_d = pcnt_q + 4'd1;
							end
							PH_LEN: begin
								len_word = remain_q | (32'(b) << {pcnt_q[1:0], 3'b000});
								remain_d = len_word;
								pcnt_d   = pcnt_q + 4'd1;
								if (pcnt_q >= LEN_PREFIX_LAST) begin
									if (len_word == '0) begin
										res_d.record_last = 1'b1;
										phase_d  = PH_ID;
										key_d    = '0;
										pcnt_d   = '0;
										remain_d = '0;
										since_d  = '0;
									end else begin
										phase_d = PH_BODY;
									end
								end
							end
							PH_BODY: begin
								remain_d = (remain_q != '0) ? remain_q - 32'd1 : remain_q;
								if (remain_d == '0) begin
									res_d.record_last = 1'b1;
									phase_d  = PH_ID;
									key_d    = '0;
									pcnt_d   = '0;
									since_d  = '0;
								end
							end
							default: begin
								emit = 1'b0;
							end
						endcase
					end
				end
				OP_END: begin
					emit                 = 1'b1;
					res_d.kind           = KIND_END;
					res_d.record_key     = '0;
					res_d.record_byte    = '0;
					res_d.leftover_count = (phase_q == PH_DROP) ? '0 : since_q;
					phase_d  = PH_ID;
					key_d    = '0;
					pcnt_d   = '0;
					remain_d = '0;
					since_d  = '0;
				end
				default: begin
				end
			endcase
		end

		// Lookup byte: count it now, emit on resolve
		if (cmd.capture) begin
			since_d = since_inc;
		end

		if (cmd.resolve) begin
			emit               = 1'b1;
			res_d.record_byte  = byte_s1;
			res_d.record_first = 1'b1;
			if (!hit) begin
				res_d.kind        = KIND_ERROR;
				res_d.record_byte = '0;
				res_d.record_first = 1'b0;
				phase_d = PH_DROP;
			end else if (hit_len == '0) begin
				remain_d = 32'(byte_s1);
				pcnt_d   = 4'd1;
				phase_d  = PH_LEN;
			end else if (hit_len == 32'd1) begin
				res_d.record_last = 1'b1;
				phase_d  = PH_ID;
				key_d    = '0;
				pcnt_d   = '0;
				remain_d = '0;
				since_d  = '0;
			end else begin
				remain_d = hit_len - 32'd1;
				phase_d  = PH_BODY;
			end
		end
	end

	// Parser and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_bytes_q <= ID_BYTES_RESET;
			phase_q    <= PH_ID;
			key_q      <= '0;
			pcnt_q     <= '0;
			remain_q   <= '0;
			since_q    <= '0;
		end else begin
			if (id_bytes_we) begin
				id_bytes_q <= id_bytes_wdata;
			end
			phase_q  <= phase_d;
			key_q    <= key_d;
			pcnt_q   <= pcnt_d;
			remain_q <= remain_d;
			since_q  <= since_d;
		end
	end

	// Slot in-use bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_in_use_q <= '0;
		end else if (load_we) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (32'(item_word.entry_index) == i) begin
					slot_in_use_q[i] <= item_word.entry_valid;
				end
			end
		end
	end

	// Slot keys and lengths
	always_ff @(posedge clk) begin
		if (load_we) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (32'(item_word.entry_index) == i) begin
					slot_key_q[i] <= item_word.entry_key;
					slot_len_q[i] <= item_word.entry_length;
				end
			end
		end
	end

	// Register the key compares and the byte that triggered the lookup
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_s1 <= b;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				match_s1[i] <= slot_in_use_q[i] && (slot_key_q[i] == key_q);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

endmodule

### src/record_id_demultiplexer.sv
`timescale 1ns / 1ps
// Top level of the record id demultiplexer: controller, datapath and channel wiring.
// Depends on rid_pkg, rid_item_if, rid_result_if, rid_ctrl and rid_datapath.
//
//   channel   dir  handshake     carries
//   item      in   valid/ready   load / stream byte / end-of-block word
//   result    out  valid/ready   tagged record byte, block end, unknown id
//   id_bytes  in   write enable  id length in bytes (4 bits)
//
// Load, id, length-prefix, body and end-of-block words need no table lookup.
// For the byte right after a record id, the table compares are registered
// first, then the lowest hit is selected and its length read.
// Reset clears the slot in-use bits at once; there is no clearing pass.
// A word is accepted only while the result register is empty or being drained.
module record_id_demultiplexer #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	rid_item_if.sink   item,
	rid_result_if.source result,
	input  logic       id_bytes_we,
	input  logic [3:0] id_bytes_wdata
);
	import rid_pkg::*;

	item_t   item_word;
	result_t res_word;
	cmd_t    cmd;
	status_t status;
	logic    res_valid;

	assign item_word.op           = item.op;
	assign item_word.entry_index  = item.entry_index;
	assign item_word.entry_valid  = item.entry_valid;
	assign item_word.entry_key    = item.entry_key;
	assign item_word.entry_length = item.entry_length;
	assign item_word.data_byte    = item.data_byte;

	rid_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	rid_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.id_bytes_we    (id_bytes_we),
		.id_bytes_wdata (id_bytes_wdata),
		.item_word      (item_word),
		.cmd            (cmd),
		.status         (status),
		.res_valid      (res_valid),
		.res_ready      (result.ready),
		.res_word       (res_word)
	);

	// Drive the result channel
	assign result.valid          = res_valid;
	assign result.kind           = res_word.kind;
	assign result.record_key     = res_word.record_key;
	assign result.record_byte    = res_word.record_byte;
	assign result.record_first   = res_word.record_first;
	assign result.record_last    = res_word.record_last;
	assign result.leftover_count = res_word.leftover_count;

endmodule

### bench/rid_record_checker.sv
`timescale 1ns / 1ps
// Checker for the record id demultiplexer: watches the item and result channels,
// predicts each result word and compares it. Depends on rid_pkg and both interfaces.
module rid_record_checker #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	rid_item_if        item,
	rid_result_if      result,
	input  logic       id_bytes_we,
	input  logic [3:0] id_bytes_wdata,
	output int         fail_count,
	output int         pending_count
);
	import rid_pkg::*;

	localparam int REPORT_LIMIT = 100;

	// Mirror of the id table and the stream parser
	logic        slot_used [TABLE_ENTRIES];
	logic [63:0] slot_key  [TABLE_ENTRIES];
	logic [31:0] slot_len  [TABLE_ENTRIES];
	phase_t      phase;
	logic [63:0] key_acc;
	logic [31:0] phase_cnt;
	logic [32:0] body_left;
	logic [31:0] rec_bytes;
	logic [3:0]  id_width;

	result_t     demux_out_q [$];
	int          mismatches;
	item_t       word;
	result_t     want;
	result_t     next_out;
	bit          emits;

	task automatic rewind_parser();
		phase     = PH_ID;
		key_acc   = '0;
		phase_cnt = '0;
		body_left = '0;
		rec_bytes = '0;
	endtask

	// Advance the parser by one accepted word; emits tells whether a result follows
	task automatic demux_step(input item_t w, output bit emits, output result_t r);
		logic [3:0]  nid;
		logic [63:0] key;
		int          hit;
		nid   = (id_width > ID_BYTES_MAX) ? ID_BYTES_MAX : id_width;
		key   = key_acc;
		emits = 1'b0;
		r     = '0;
		case (w.op)
			OP_LOAD: begin
				slot_used[w.entry_index] = w.entry_valid;
				slot_key[w.entry_index]  = w.entry_key;
				slot_len[w.entry_index]  = w.entry_length;
			end
			OP_END: begin
				r.kind           = KIND_END;
				r.leftover_count = (phase == PH_DROP) ? 32'd0 : rec_bytes;
				rewind_parser();
				emits = 1'b1;
			end
			OP_BYTE: begin
				if (phase != PH_DROP) begin
					if (rec_bytes != 32'hFFFF_FFFF)
						rec_bytes++;
					r.kind        = KIND_BYTE;
					r.record_key  = key;
					r.record_byte = w.data_byte;
					emits         = 1'b1;
					case (phase)
						PH_ID: begin
							if (phase_cnt < nid) begin
								// gather the id, least significant byte first
								key_acc |= {56'd0, w.data_byte} << (phase_cnt[2:0] * 8);
								phase_cnt++;
								emits = 1'b0;
							end else begin
								// lowest matching slot wins
								hit = -1;
								for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
									if (slot_used[i] && slot_key[i] == key_acc)
										hit = i;
								r.record_first = 1'b1;
								if (hit < 0) begin
									phase          = PH_DROP;
									r.kind         = KIND_ERROR;
									r.record_byte  = '0;
									r.record_first = 1'b0;
								end else if (slot_len[hit] == 32'd0) begin
									body_left = {25'd0, w.data_byte};
									phase_cnt = 32'd1;
									phase     = PH_LEN;
								end else if (slot_len[hit] == 32'd1) begin
									rewind_parser();
									r.record_last = 1'b1;
								end else begin
									body_left = {1'b0, slot_len[hit]} - 33'd1;
									phase     = PH_BODY;
								end
							end
						end
						PH_LEN: begin
							body_left |= {25'd0, w.data_byte} << (phase_cnt[1:0] * 8);
							phase_cnt++;
							if (phase_cnt > LEN_PREFIX_LAST) begin
								if (body_left == '0) begin
									rewind_parser();
									r.record_last = 1'b1;
								end else begin
									phase = PH_BODY;
								end
							end
						end
						default: begin
							if (body_left != '0)
								body_left--;
							if (body_left == '0) begin
								rewind_parser();
								r.record_last = 1'b1;
							end
						end
					endcase
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] got_v);
		if (got_v !== exp_v) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
		end
	endtask

	// Compare result words first: none of them can stem from a word accepted at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				slot_used[i] = 1'b0;
				slot_key[i]  = '0;
				slot_len[i]  = '0;
			end
			rewind_parser();
			id_width   = ID_BYTES_RESET;
			mismatches = 0;
			demux_out_q.delete();
			pending_count <= 0;
			fail_count    <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (demux_out_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: result word with none expected, expected nothing, actual kind %h key %h byte %h",
							$time, result.kind, result.record_key, result.record_byte);
				end else begin
					want = demux_out_q.pop_front();
					check_field("kind", 64'(want.kind), 64'(result.kind));
					check_field("record_key", want.record_key, result.record_key);
					check_field("record_byte", 64'(want.record_byte), 64'(result.record_byte));
					check_field("record_first", 64'(want.record_first), 64'(result.record_first));
					check_field("record_last", 64'(want.record_last), 64'(result.record_last));
					check_field("leftover_count", 64'(want.leftover_count),
						64'(result.leftover_count));
				end
			end
			if (item.valid && item.ready) begin
				word.op           = item.op;
				word.entry_index  = item.entry_index;
				word.entry_valid  = item.entry_valid;
				word.entry_key    = item.entry_key;
				word.entry_length = item.entry_length;
				word.data_byte    = item.data_byte;
				demux_step(word, emits, next_out);
				if (emits)
					demux_out_q.push_back(next_out);
			end
			if (id_bytes_we)
				id_width = id_bytes_wdata;
			pending_count <= demux_out_q.size();
			fail_count    <= mismatches;
		end
	end

endmodule

### bench/tb_record_id_demultiplexer.sv
`timescale 1ns / 1ps
// Testbench top for the record id demultiplexer: clock, reset, stimulus and verdict.
// Depends on rid_pkg, rid_item_if, rid_result_if, rid_record_checker and the block.
module tb_record_id_demultiplexer;
	import rid_pkg::*;

	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         SETTLE_CYCLES  = 4;
	localparam int         PHASE_WORDS    = 100;

	logic       clk;
	logic       arst_n;
	logic       id_bytes_we;
	logic [3:0] id_bytes_wdata;

	rid_item_if   item_ch ();
	rid_result_if result_ch ();

	int fail_count;
	int pending_count;
	int idle_cycles;
	int stall_left;
	int words_sent;
	int records_sent;
	int settings_used;
	int cur_nid;
	bit calm;

	// Generator's view of the table, used only to shape well-formed records
	logic [63:0] tbl_key  [16];
	logic [31:0] tbl_len  [16];
	logic        tbl_used [16];

	record_id_demultiplexer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item_ch),
		.result         (result_ch),
		.id_bytes_we    (id_bytes_we),
		.id_bytes_wdata (id_bytes_wdata)
	);

	rid_record_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item_ch),
		.result         (result_ch),
		.id_bytes_we    (id_bytes_we),
		.id_bytes_wdata (id_bytes_wdata),
		.fail_count     (fail_count),
		.pending_count  (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [63:0] id_mask(input int n);
		return (n >= 8) ? {64{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);
	endfunction

	// Stall the result side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left      <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (calm || $urandom_range(0, 99) < 60) begin
			result_ch.ready <= 1'b1;
			stall_left      <= calm ? 0 : $urandom_range(0, 8);
		end else begin
			result_ch.ready <= 1'b0;
			stall_left      <= pick_gap();
		end
	end

	// End the run when no word moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
				$display("tb_record_id_demultiplexer NOT OK");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offer one word after a random gap and hold it until accepted
	task automatic send_word(input logic [1:0] op, input logic [3:0] idx, input logic vld,
		input logic [63:0] key, input logic [31:0] len, input logic [7:0] data);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.op           <= op;
		item_ch.entry_index  <= idx;
		item_ch.entry_valid  <= vld;
		item_ch.entry_key    <= key;
		item_ch.entry_length <= len;
		item_ch.data_byte    <= data;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(OP_BYTE, 4'($urandom), 1'($urandom), {$urandom, $urandom}, $urandom, b);
	endtask

	task automatic send_end();
		send_word(OP_END, 4'($urandom), 1'($urandom), {$urandom, $urandom}, $urandom,
			8'($urandom));
	endtask

	task automatic send_noise();
		send_word(OP_UNUSED, 4'($urandom), 1'($urandom), {$urandom, $urandom}, $urandom,
			8'($urandom));
	endtask

	task automatic set_slot(input int i, input logic vld, input logic [63:0] key,
		input logic [31:0] len);
		tbl_used[i] = vld;
		tbl_key[i]  = key;
		tbl_len[i]  = len;
		send_word(OP_LOAD, 4'(i), vld, key, len, 8'($urandom));
	endtask

	// Random slot: duplicates of lower keys are common, most lengths short
	task automatic load_slot(input int i);
		logic [63:0] key;
		logic [31:0] len;
		int          r;
		if (i > 0 && $urandom_range(0, 3) == 0)
			key = tbl_key[$urandom_range(0, i - 1)];
		else
			key = {$urandom, $urandom} & id_mask(cur_nid);
		r = $urandom_range(0, 19);
		if (r == 0)
			len = $urandom;
		else if (r < 3)
			len = 32'd1;
		else if (r < 10)
			len = 32'd0;
		else
			len = $urandom_range(2, 12);
		set_slot(i, $urandom_range(0, 99) < 80, key, len);
	endtask

	// Hold the sender until every expected result word has come
	task automatic drain_results();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	task automatic write_id_bytes(input logic [3:0] v);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		id_bytes_we    <= 1'b1;
		id_bytes_wdata <= v;
		@(posedge clk);
		id_bytes_we <= 1'b0;
		cur_nid = int'((v > ID_BYTES_MAX) ? ID_BYTES_MAX : v);
		settings_used++;
	endtask

	// One record: id, then fixed body or prefix and body; cut ones end the block early
	task automatic send_record(input bit cut);
		logic [63:0] key;
		logic [31:0] plen;
		logic [33:0] total;
		logic [33:0] nsend;
		int          hit;
		bit          prefixed;
		bit          trunc;
		trunc = cut;
		if ($urandom_range(0, 11) == 0)
			key = {$urandom, $urandom} & id_mask(cur_nid);
		else
			key = tbl_key[$urandom_range(0, 15)] & id_mask(cur_nid);
		hit = -1;
		for (int i = 15; i >= 0; i--)
			if (tbl_used[i] && tbl_key[i] == key)
				hit = i;
		records_sent++;
		for (int i = 0; i < cur_nid; i++)
			send_byte(key[8 * i +: 8]);
		if (hit < 0) begin
			// unknown id: error, then the rest of the block is dropped
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
			send_end();
			return;
		end
		prefixed = (tbl_len[hit] == 32'd0);
		plen     = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 10) : $urandom;
		total    = prefixed ? ({2'b0, plen} + 34'd4) : {2'b0, tbl_len[hit]};
		if (total > 34'd40)
			trunc = 1'b1;
		nsend = trunc ? $urandom_range(0, (total > 34'd9) ? 8 : 32'(total - 34'd1)) : total;
		for (int j = 0; j < nsend; j++)
			send_byte((prefixed && j < 4) ? plen[8 * j +: 8] : 8'($urandom));
		if (trunc)
			send_end();
	endtask

	task automatic run_phase(input logic [3:0] width, input bit quiet);
		int  start;
		int  r;
		bit  paused;
		write_id_bytes(width);
		calm   = quiet;
		paused = 1'b0;
		for (int i = 0; i < 16; i++)
			load_slot(i);
		start = words_sent;
		while (words_sent - start < PHASE_WORDS) begin
			if (!paused && words_sent - start >= PHASE_WORDS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 78) begin
				send_record($urandom_range(0, 9) == 0);
			end else if (r < 86) begin
				send_end();
			end else if (r < 90) begin
				send_noise();
			end else if (r < 95) begin
				load_slot($urandom_range(0, 15));
			end else begin
				// stray bytes knock the parser off the record grid until the block ends
				repeat ($urandom_range(1, 2)) send_byte(8'($urandom));
				send_end();
			end
		end
		send_end();
		calm = 1'b0;
	endtask

	initial begin
		arst_n               <= 1'b0;
		id_bytes_we          <= 1'b0;
		id_bytes_wdata       <= '0;
		item_ch.valid        <= 1'b0;
		item_ch.op           <= OP_LOAD;
		item_ch.entry_index  <= '0;
		item_ch.entry_valid  <= 1'b0;
		item_ch.entry_key    <= '0;
		item_ch.entry_length <= '0;
		item_ch.data_byte    <= '0;
		idle_cycles   = 0;
		words_sent    = 0;
		records_sent  = 0;
		settings_used = 0;
		cur_nid       = int'(ID_BYTES_RESET);
		calm          = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset id width of one byte
		set_slot(0, 1'b1, 64'h5A, 32'd1);
		set_slot(1, 1'b1, 64'h5A, 32'd3);
		set_slot(2, 1'b1, 64'h33, 32'd0);
		set_slot(3, 1'b1, 64'hFF, 32'd2);
		set_slot(4, 1'b0, 64'h77, 32'd5);
		set_slot(5, 1'b1, 64'h00, 32'hFFFF_FFFF);
		set_slot(6, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'd4);
		for (int i = 7; i < 16; i++)
			set_slot(i, 1'b0, {$urandom, $urandom}, $urandom);

		// one-byte record, the lower duplicate slot wins
		send_byte(8'h5A); send_byte(8'hFF);
		// length prefix of zero: last mark on the fourth prefix byte
		send_byte(8'h33); repeat (4) send_byte(8'h00);
		// length prefix of one
		send_byte(8'h33); send_byte(8'h01); repeat (3) send_byte(8'h00); send_byte(8'hFF);
		// fixed body of two
		send_byte(8'hFF); send_byte(8'h00); send_byte(8'hFF);
		// block ends right after an id
		send_byte(8'h5A); send_end();
		send_noise();
		// huge body cut short by the end of the block
		send_byte(8'h00); send_byte(8'hAA); send_byte(8'h55); send_byte(8'h00); send_end();
		// unknown id: one error, then dropped bytes, leftover zero
		send_byte(8'h77); send_byte(8'h12); send_byte(8'h34); send_end();
		send_end();
		// shrink the id width in the middle of an id
		write_id_bytes(4'd2);
		send_byte(8'h5A);
		write_id_bytes(4'd1);
		send_byte(8'h00);

		// Random phases over several id widths, the extremes among them
		run_phase(4'd0, 1'b0);
		run_phase(4'd8, 1'b0);
		run_phase(4'd15, 1'b1);
		run_phase(4'd2, 1'b0);
		run_phase(4'd4, 1'b0);
		run_phase(4'd3, 1'b0);
		run_phase(4'($urandom_range(0, 15)), 1'b0);

		drain_results();
		calm = 1'b1;
		repeat (64) @(posedge clk);

		$display("run covered %0d input words in %0d records over %0d id width writes",
			words_sent, records_sent, settings_used);
		$display("loads, length prefixed and fixed records, unknown ids, cut blocks; %0d mismatches",
			fail_count);
		if (fail_count == 0)
			$display("tb_record_id_demultiplexer OK");
		else
			$display("tb_record_id_demultiplexer NOT OK");
		$finish;
	end

endmodule
